>>> rtl/core/swsfd_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire sensor frame decoder package
// Shared widths, codes, item types and the checksum function.
// ----------------------------------------------------------------------------
package swsfd_pkg;

   localparam int TIME_W = 32;
   localparam int THR_W  = 16;
   localparam int WORD_W = 16;
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 4;

   localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd100;
   localparam logic [WORD_W-1:0] WORD_MSB        = 16'h8000;
   localparam logic [BYTE_W-1:0] BYTE_MSB        = 8'h80;
   localparam logic [IDX_W-1:0]  WORD_LAST_IDX   = 4'd15;
   localparam logic [IDX_W-1:0]  BYTE_LAST_IDX   = 4'd7;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_EDGE  = 1'b1
   } req_code_type;

   typedef enum logic [1:0] {
      ST_BUSY   = 2'd0,
      ST_OK     = 2'd1,
      ST_NOACK  = 2'd2,
      ST_BADSUM = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_ACK  = 5'b00001,
      PH_HUM  = 5'b00010,
      PH_TEMP = 5'b00100,
      PH_CHK  = 5'b01000,
      PH_END  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic              req_type;
      logic [TIME_W-1:0] edge_time_us;
   } req_item_type;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] humidity_word;
      logic [WORD_W-1:0] temperature_word;
      logic [BYTE_W-1:0] checksum_byte;
   } rsp_item_type;

   typedef struct packed {
      phase_type         phase;
      logic [IDX_W-1:0]  bit_idx;
      logic              awaiting;
      logic [TIME_W-1:0] ref_time;
      status_type        status;
      logic [WORD_W-1:0] hum;
      logic [WORD_W-1:0] temp;
      logic [BYTE_W-1:0] chk;
   } dec_state_type;

   localparam dec_state_type DEC_ARMED = '{
      phase:    PH_ACK,
      bit_idx:  '0,
      awaiting: 1'b1,
      ref_time: '0,
      status:   ST_BUSY,
      hum:      '0,
      temp:     '0,
      chk:      '0
   };

   function automatic logic [BYTE_W-1:0] checksum_of(
      input logic [WORD_W-1:0] hum,
      input logic [WORD_W-1:0] temp
   );
      checksum_of = hum[WORD_W-1:BYTE_W] + hum[BYTE_W-1:0]
                  + temp[WORD_W-1:BYTE_W] + temp[BYTE_W-1:0];
   endfunction

endpackage

>>> rtl/core/swsfd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one decoder request item.
// ----------------------------------------------------------------------------
interface swsfd_req_if
   import swsfd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [TIME_W-1:0] edge_time_us;

   modport source (output valid, req_type, edge_time_us, input ready);
   modport sink   (input valid, req_type, edge_time_us, output ready);
endinterface

>>> rtl/core/swsfd_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one decoder result item.
// ----------------------------------------------------------------------------
interface swsfd_rsp_if
   import swsfd_pkg::*;
();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [WORD_W-1:0] humidity_word;
   logic [WORD_W-1:0] temperature_word;
   logic [BYTE_W-1:0] checksum_byte;

   modport source (output valid, status, humidity_word, temperature_word, checksum_byte,
                   input ready);
   modport sink   (input valid, status, humidity_word, temperature_word, checksum_byte,
                   output ready);
endinterface

>>> rtl/core/swsfd_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the bit threshold register.
// ----------------------------------------------------------------------------
interface swsfd_csr_if
   import swsfd_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [THR_W-1:0] bit_threshold_us;

   modport source (output valid, bit_threshold_us, input ready);
   modport sink   (input valid, bit_threshold_us, output ready);
endinterface

>>> rtl/core/swsfd_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one request item until the result register can take its result.
// ----------------------------------------------------------------------------
module swsfd_in_stage
   import swsfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   swsfd_req_if.sink    req,
   input  logic         take,
   output logic         advance,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign advance   = valid_ff && take;
   assign req.ready = !valid_ff || take;
   assign valid_in  = req.ready ? req.valid : valid_ff;
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.req_type     <= req.req_type;
         item_ff.edge_time_us <= req.edge_time_us;
      end
   end

endmodule

>>> rtl/core/swsfd_decode.sv
// ----------------------------------------------------------------------------
// Frame decoder
// Holds the frame state and updates it from one item per cycle while advance is high.
// ----------------------------------------------------------------------------
module swsfd_decode
   import swsfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  req_item_type     item,
   input  logic [THR_W-1:0] threshold,
   output rsp_item_type     result,
   output dec_state_type    state
);

   dec_state_type     st_ff;
   dec_state_type     st_in;
   logic [TIME_W-1:0] delta;
   logic              bit_one;
   logic [BYTE_W-1:0] chk_new;

   assign delta   = item.edge_time_us - st_ff.ref_time;
   assign bit_one = delta >= {{(TIME_W-THR_W){1'b0}}, threshold};
   assign chk_new = st_ff.chk | (bit_one ? (BYTE_MSB >> st_ff.bit_idx[2:0]) : '0);

   always_comb begin
      st_in = st_ff;
      if (item.req_type == REQ_START) begin
         st_in = DEC_ARMED;
      end else if (st_ff.phase != PH_END) begin
         st_in.ref_time = item.edge_time_us;
         if (st_ff.awaiting) begin
            st_in.awaiting = 1'b0;
         end else begin
            unique case (st_ff.phase)
               PH_ACK: begin
                  if (bit_one) begin
                     st_in.phase   = PH_HUM;
                     st_in.bit_idx = '0;
                  end else begin
                     st_in.status = ST_NOACK;
                     st_in.phase  = PH_END;
                  end
               end
               PH_HUM: begin
                  if (bit_one) begin
                     st_in.hum = st_ff.hum | (WORD_MSB >> st_ff.bit_idx);
                  end
                  if (st_ff.bit_idx == WORD_LAST_IDX) begin
                     st_in.phase   = PH_TEMP;
                     st_in.bit_idx = '0;
                  end else begin
                     st_in.bit_idx = st_ff.bit_idx + 1'b1;
                  end
               end
               PH_TEMP: begin
                  if (bit_one) begin
                     st_in.temp = st_ff.temp | (WORD_MSB >> st_ff.bit_idx);
                  end
                  if (st_ff.bit_idx == WORD_LAST_IDX) begin
                     st_in.phase   = PH_CHK;
                     st_in.bit_idx = '0;
                  end else begin
                     st_in.bit_idx = st_ff.bit_idx + 1'b1;
                  end
               end
               PH_CHK: begin
                  st_in.chk = chk_new;
                  if (st_ff.bit_idx == BYTE_LAST_IDX) begin
                     st_in.status  = (checksum_of(st_ff.hum, st_ff.temp) == chk_new) ?
                                     ST_OK : ST_BADSUM;
                     st_in.phase   = PH_END;
                     st_in.bit_idx = '0;
                  end else begin
                     st_in.bit_idx = st_ff.bit_idx + 1'b1;
                  end
               end
               default: begin
                  st_in = st_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= DEC_ARMED;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   assign result.status           = st_in.status;
   assign result.humidity_word    = st_in.hum;
   assign result.temperature_word = st_in.temp;
   assign result.checksum_byte    = st_in.chk;
   assign state                   = st_ff;

endmodule

>>> rtl/core/swsfd_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the response channel takes it.
// ----------------------------------------------------------------------------
module swsfd_out_stage
   import swsfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         take,
   swsfd_rsp_if.source  rsp
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign take     = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp.valid            = valid_ff;
   assign rsp.status           = item_ff.status;
   assign rsp.humidity_word    = item_ff.humidity_word;
   assign rsp.temperature_word = item_ff.temperature_word;
   assign rsp.checksum_byte    = item_ff.checksum_byte;

endmodule

>>> rtl/core/single_wire_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// Single-wire sensor frame decoder
// Rebuilds a humidity/temperature frame from falling-edge timestamps.
// ----------------------------------------------------------------------------
// Every request item gives exactly one result item. The block takes one item
// per clock cycle while the response channel is not stalled. An accepted item
// passes an input register, its result is formed combinationally from the frame
// state, and the result waits in an output register. A stalled response
// channel holds both registers and then drops request ready. A start item
// clears the words and arms the decoder; the threshold register keeps its
// value and is written through the configuration channel, which is always
// ready and should be used only while no item is in flight.
module single_wire_sensor_frame_decoder
   import swsfd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   swsfd_req_if.sink   req_if,
   swsfd_rsp_if.source rsp_if,
   swsfd_csr_if.sink   csr_if
);

   logic             csr_write;
   logic [THR_W-1:0] thr_ff;
   logic [THR_W-1:0] thr_in;
   logic             take;
   logic             advance;
   req_item_type     item;
   rsp_item_type     result;
   dec_state_type    state;

   assign csr_write     = csr_if.valid && csr_if.ready;
   assign csr_if.ready  = 1'b1;
   assign thr_in        = csr_write ? csr_if.bit_threshold_us : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   swsfd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .take    (take),
      .advance (advance),
      .item    (item)
   );

   swsfd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .threshold (thr_ff),
      .result    (result),
      .state     (state)
   );

   swsfd_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (advance),
      .result (result),
      .take   (take),
      .rsp    (rsp_if)
   );

   assert property (@(posedge clock) disable iff (reset)
      state.phase == PH_END |-> state.status != ST_BUSY)
      else $error("Frame ended with busy status.");

   assert property (@(posedge clock) disable iff (reset)
      state.status == ST_OK |-> checksum_of(state.hum, state.temp) == state.chk)
      else $error("Success reported with a mismatching checksum.");

   assert property (@(posedge clock) disable iff (reset)
      state.bit_idx != '0 |->
         (state.phase == PH_HUM || state.phase == PH_TEMP || state.phase == PH_CHK))
      else $error("Bit position set outside a data phase.");

   assert property (@(posedge clock) disable iff (reset)
      advance && item.req_type == REQ_START |=>
         state.status == ST_BUSY && state.awaiting && state.phase == PH_ACK)
      else $error("Start item did not arm the decoder.");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-wire sensor frame decoder testbench
// Drives start and falling-edge items through the request channel. A short
// table of directed items comes first, followed by randomized sensor frames
// under several bit thresholds and idle patterns. Every result item is checked
// field by field against a pinned reading or a cycle-free decoding prediction.
// ----------------------------------------------------------------------------
module tb_top
   import swsfd_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 64;
   localparam int PHASE_ITEMS    = 150;
   localparam int PHASE_COUNT    = 6;

   localparam rsp_item_type NO_READING    = '0;
   localparam rsp_item_type BUSY_READING  = '{ST_BUSY, 16'h0000, 16'h0000, 8'h00};
   localparam rsp_item_type NOACK_READING = '{ST_NOACK, 16'h0000, 16'h0000, 8'h00};

   typedef struct packed {
      req_code_type code;
      logic [31:0]  stamp;
      bit           pinned;
      rsp_item_type reading;
   } directed_row_type;

   typedef struct packed {
      bit           pinned;
      rsp_item_type reading;
   } item_note_type;

   typedef struct {
      logic [31:0] last_edge;
      bit          first_pending;
      phase_type   phase;
      int          bit_pos;
      logic [15:0] hum;
      logic [15:0] temp;
      logic [7:0]  chk;
      status_type  status;
   } frame_track_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swsfd_req_if req_ch ();
   swsfd_rsp_if rsp_ch ();
   swsfd_csr_if csr_ch ();

   single_wire_sensor_frame_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   frame_track_type sensor;
   logic [15:0]  decode_threshold;
   logic [15:0]  gap_threshold = THRESHOLD_RESET;
   rsp_item_type expected_readings [$];
   item_note_type item_notes [$];
   int           accepted_items = 0;
   int           mismatch_count = 0;
   int           quiet_cycles   = 0;
   int           req_idle_pct   = 16;
   int           rsp_idle_pct   = 56;
   int           hold_requests  = 0;

   directed_row_type directed_rows [22] = '{
      '{REQ_EDGE,  32'h0000_0000, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'hFFFF_FFFF, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'h0000_0063, 1'b0, NO_READING},
      '{REQ_EDGE,  32'h0000_00C6, 1'b0, NO_READING},
      '{REQ_EDGE,  32'h0000_00C6, 1'b0, NO_READING},
      '{REQ_EDGE,  32'h7FFF_FFFF, 1'b0, NO_READING},
      '{REQ_START, 32'hFFFF_FFFF, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'hFFFF_FFFF, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'hFFFF_FFFF, 1'b1, NOACK_READING},
      '{REQ_EDGE,  32'h0000_0000, 1'b1, NOACK_READING},
      '{REQ_EDGE,  32'h1234_5678, 1'b1, NOACK_READING},
      '{REQ_START, 32'h0000_0000, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'h8000_0000, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'h8000_0064, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'h8000_00C7, 1'b0, NO_READING},
      '{REQ_EDGE,  32'h8000_012B, 1'b0, NO_READING},
      '{REQ_EDGE,  32'h8001_012A, 1'b0, NO_READING},
      '{REQ_EDGE,  32'h8001_012B, 1'b0, NO_READING},
      '{REQ_START, 32'h5A5A_5A5A, 1'b1, BUSY_READING},
      '{REQ_START, 32'hA5A5_A5A5, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'hFFFF_FF9C, 1'b1, BUSY_READING},
      '{REQ_EDGE,  32'h0000_0000, 1'b1, BUSY_READING}
   };

   function automatic frame_track_type armed_frame();
      frame_track_type fresh;
      fresh.last_edge     = '0;
      fresh.first_pending = 1'b1;
      fresh.phase         = PH_ACK;
      fresh.bit_pos       = 0;
      fresh.hum           = '0;
      fresh.temp          = '0;
      fresh.chk           = '0;
      fresh.status        = ST_BUSY;
      return fresh;
   endfunction

   function automatic rsp_item_type advance_frame(input logic code, input logic [31:0] stamp);
      logic [31:0]  gap;
      logic         one;
      logic [7:0]   sum;
      rsp_item_type reading;
      if (code == REQ_START) begin
         sensor = armed_frame();
      end else if (sensor.phase != PH_END) begin
         if (sensor.first_pending) begin
            sensor.last_edge     = stamp;
            sensor.first_pending = 1'b0;
         end else begin
            gap              = stamp - sensor.last_edge;
            sensor.last_edge = stamp;
            one              = (gap >= 32'(decode_threshold));
            case (sensor.phase)
               PH_ACK: begin
                  if (one) begin
                     sensor.phase   = PH_HUM;
                     sensor.bit_pos = 0;
                  end else begin
                     sensor.status = ST_NOACK;
                     sensor.phase  = PH_END;
                  end
               end
               PH_HUM: begin
                  if (one) sensor.hum[15 - sensor.bit_pos] = 1'b1;
                  sensor.bit_pos++;
                  if (sensor.bit_pos == 16) begin
                     sensor.phase   = PH_TEMP;
                     sensor.bit_pos = 0;
                  end
               end
               PH_TEMP: begin
                  if (one) sensor.temp[15 - sensor.bit_pos] = 1'b1;
                  sensor.bit_pos++;
                  if (sensor.bit_pos == 16) begin
                     sensor.phase   = PH_CHK;
                     sensor.bit_pos = 0;
                  end
               end
               PH_CHK: begin
                  if (one) sensor.chk[7 - sensor.bit_pos] = 1'b1;
                  sensor.bit_pos++;
                  if (sensor.bit_pos == 8) begin
                     sum = sensor.hum[15:8] + sensor.hum[7:0]
                         + sensor.temp[15:8] + sensor.temp[7:0];
                     sensor.status  = (sum == sensor.chk) ? ST_OK : ST_BADSUM;
                     sensor.phase   = PH_END;
                     sensor.bit_pos = 0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      reading.status           = sensor.status;
      reading.humidity_word    = sensor.hum;
      reading.temperature_word = sensor.temp;
      reading.checksum_byte    = sensor.chk;
      return reading;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 100) begin
         $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      item_note_type note;
      rsp_item_type  want;
      if (reset) begin
         sensor           = armed_frame();
         decode_threshold = THRESHOLD_RESET;
         quiet_cycles     = 0;
      end else begin
         quiet_cycles++;
         if (csr_ch.valid && csr_ch.ready) begin
            decode_threshold = csr_ch.bit_threshold_us;
            quiet_cycles     = 0;
         end
         if (req_ch.valid && req_ch.ready) begin
            note = item_notes.pop_front();
            accepted_items++;
            want = advance_frame(req_ch.req_type, req_ch.edge_time_us);
            if (note.pinned) want = note.reading;
            expected_readings.push_back(want);
            quiet_cycles = 0;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            quiet_cycles = 0;
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected result item", rsp_ch.status, '0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", rsp_ch.status, want.status);
               if (rsp_ch.humidity_word !== want.humidity_word)
                  report_mismatch("humidity_word", rsp_ch.humidity_word, want.humidity_word);
               if (rsp_ch.temperature_word !== want.temperature_word)
                  report_mismatch("temperature_word", rsp_ch.temperature_word,
                                  want.temperature_word);
               if (rsp_ch.checksum_byte !== want.checksum_byte)
                  report_mismatch("checksum_byte", rsp_ch.checksum_byte, want.checksum_byte);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int hold_left;
      int hold_served;
      hold_left     = 0;
      hold_served   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic offer_request(input req_code_type code, input logic [31:0] stamp,
                                input bit pinned, input rsp_item_type pinned_reading);
      item_note_type note;
      note.pinned  = pinned;
      note.reading = pinned_reading;
      item_notes.push_back(note);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= code;
      req_ch.edge_time_us <= stamp;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_readings.size() != 0);
   endtask

   task automatic write_threshold(input logic [15:0] value);
      csr_ch.valid            <= 1'b1;
      csr_ch.bit_threshold_us <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid  <= 1'b0;
      gap_threshold = value;
   endtask

   function automatic logic [31:0] bit_gap(input logic one);
      logic [31:0] min_gap;
      min_gap = 32'(gap_threshold);
      if (one || gap_threshold == 0) begin
         case ($urandom_range(0, 3))
            0: return min_gap;
            1: return min_gap + $urandom_range(0, 255);
            2: return min_gap + $urandom_range(0, 65535);
            default: return $urandom_range(min_gap, 32'hFFFF_FFFF);
         endcase
      end
      if ($urandom_range(0, 1) == 0) return min_gap - 1;
      return $urandom_range(0, min_gap - 1);
   endfunction

   task automatic send_frame();
      logic [15:0] hum_v;
      logic [15:0] temp_v;
      logic [7:0]  chk_v;
      logic [40:0] bits;
      logic [31:0] stamp;
      int          cut;
      int          extra;
      int          i;
      hum_v  = 16'($urandom);
      temp_v = 16'($urandom);
      chk_v  = hum_v[15:8] + hum_v[7:0] + temp_v[15:8] + temp_v[7:0];
      if ($urandom_range(0, 3) == 0) chk_v = 8'($urandom);
      bits = {1'b1, hum_v, temp_v, chk_v};
      if ($urandom_range(0, 9) == 0) bits[40] = 1'b0;
      cut = 41;
      if ($urandom_range(0, 7) == 0) cut = $urandom_range(0, 40);
      stamp = $urandom;
      if ($urandom_range(0, 5) == 0) stamp = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      if ($urandom_range(0, 19) != 0) offer_request(REQ_START, $urandom, 1'b0, NO_READING);
      offer_request(REQ_EDGE, stamp, 1'b0, NO_READING);
      for (i = 0; i < cut; i++) begin
         stamp = stamp + bit_gap(bits[40 - i]);
         offer_request(REQ_EDGE, stamp, 1'b0, NO_READING);
      end
      extra = $urandom_range(0, 2);
      for (i = 0; i < extra; i++) offer_request(REQ_EDGE, $urandom, 1'b0, NO_READING);
   endtask

   initial begin
      logic [15:0] phase_thresholds [PHASE_COUNT];
      logic [15:0] value;
      int          phase_no;
      int          target;
      phase_thresholds = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd100, 16'd37};
      req_ch.valid            = 1'b0;
      req_ch.req_type         = REQ_START;
      req_ch.edge_time_us     = '0;
      csr_ch.valid            = 1'b0;
      csr_ch.bit_threshold_us = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         offer_request(directed_rows[r].code, directed_rows[r].stamp,
                       directed_rows[r].pinned, directed_rows[r].reading);
      end

      for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
         drain_results();
         value = phase_thresholds[phase_no];
         if (phase_no == 3) value = 16'($urandom_range(2, 65534));
         write_threshold(value);
         case (phase_no / 2)
            0: begin
               req_idle_pct = 16;
               rsp_idle_pct = 56;
            end
            1: begin
               req_idle_pct = 56;
               rsp_idle_pct = 16;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         hold_requests++;
         target = accepted_items + PHASE_ITEMS;
         while (accepted_items < target) send_frame();
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (expected_readings.size() != 0) begin
         report_mismatch("leftover expected readings", expected_readings.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/swsfd_pkg.sv
rtl/core/swsfd_req_if.sv
rtl/core/swsfd_rsp_if.sv
rtl/core/swsfd_csr_if.sv
rtl/core/swsfd_in_stage.sv
rtl/core/swsfd_decode.sv
rtl/core/swsfd_out_stage.sv
rtl/core/single_wire_sensor_frame_decoder.sv
tb/tb_top.sv
